// ----- sv/fqps_pkg.sv -----
// ---------------------------------------------------------------------------
// fqps_pkg
// shared types, codes and defaults for the record queue with partition sum
// ---------------------------------------------------------------------------
package fqps_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int SUM_W           = 36;
    localparam int OCC_W           = 5;

    // command codes carried on s_cmd
    typedef enum logic [2:0] {
        OP_ENQ   = 3'd0,
        OP_DEQ   = 3'd1,
        OP_CLEAR = 3'd2,
        OP_PEEK  = 3'd3,
        OP_SUM   = 3'd4
    } op_t;

    // result status codes carried on m_status
    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2
    } status_t;

    // one queue record as held in memory
    typedef struct packed {
        logic        [31:0] tag;
        logic signed [31:0] prize;
        logic        [7:0]  rtype;
        logic signed [31:0] tstamp;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    // sweep selection during the partition
    typedef enum logic [1:0] {
        PASS_MATCH = 2'd0,
        PASS_OTHER = 2'd1,
        PASS_COPY  = 2'd2
    } pass_sel_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_EXEC,
        CS_READ,
        CS_MATCH,
        CS_OTHER,
        CS_COPY,
        CS_EMIT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic      take;
        logic      exec;
        logic      capture;
        logic      pass_run;
        logic      pass_restart;
        pass_sel_t pass_sel;
        logic      emit;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t  op;
        logic empty;
        logic pass_done;
        logic out_free;
    } dp_status_t;

endpackage

// ----- sv/fqps_ram.sv -----
// ---------------------------------------------------------------------------
// fqps_ram
// simple dual-port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module fqps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/fqps_ctrl.sv -----
// ---------------------------------------------------------------------------
// fqps_ctrl
// command sequencer: decode, memory read wait, three partition sweeps, emit
// ---------------------------------------------------------------------------
module fqps_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  fqps_pkg::dp_status_t   sts,
    output fqps_pkg::ctrl_cmd_t    cmd
);

    fqps_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fqps_pkg::CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fqps_pkg::CS_IDLE: begin
                if (s_valid) state_next = fqps_pkg::CS_EXEC;
            end
            fqps_pkg::CS_EXEC: begin
                if (sts.empty) begin
                    state_next = fqps_pkg::CS_EMIT;
                end else begin
                    unique case (sts.op) inside
                        fqps_pkg::OP_DEQ,
                        fqps_pkg::OP_PEEK: state_next = fqps_pkg::CS_READ;
                        fqps_pkg::OP_SUM:  state_next = fqps_pkg::CS_MATCH;
                        default:           state_next = fqps_pkg::CS_EMIT;
                    endcase
                end
            end
            fqps_pkg::CS_READ:  state_next = fqps_pkg::CS_EMIT;
            fqps_pkg::CS_MATCH: begin
                if (sts.pass_done) state_next = fqps_pkg::CS_OTHER;
            end
            fqps_pkg::CS_OTHER: begin
                if (sts.pass_done) state_next = fqps_pkg::CS_COPY;
            end
            fqps_pkg::CS_COPY: begin
                if (sts.pass_done) state_next = fqps_pkg::CS_EMIT;
            end
            fqps_pkg::CS_EMIT: begin
                if (sts.out_free) state_next = fqps_pkg::CS_IDLE;
            end
            default: state_next = fqps_pkg::CS_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd          = '0;
        cmd.pass_sel = fqps_pkg::PASS_MATCH;
        s_ready      = 1'b0;
        unique case (state_reg)
            fqps_pkg::CS_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
            end
            fqps_pkg::CS_EXEC: cmd.exec = 1'b1;
            fqps_pkg::CS_READ: cmd.capture = 1'b1;
            fqps_pkg::CS_MATCH: begin
                cmd.pass_run     = 1'b1;
                cmd.pass_sel     = fqps_pkg::PASS_MATCH;
                cmd.pass_restart = sts.pass_done;
            end
            fqps_pkg::CS_OTHER: begin
                cmd.pass_run     = 1'b1;
                cmd.pass_sel     = fqps_pkg::PASS_OTHER;
                cmd.pass_restart = sts.pass_done;
            end
            fqps_pkg::CS_COPY: begin
                cmd.pass_run = 1'b1;
                cmd.pass_sel = fqps_pkg::PASS_COPY;
            end
            fqps_pkg::CS_EMIT: cmd.emit = sts.out_free;
            default: ;
        endcase
    end

endmodule

// ----- sv/fqps_dp.sv -----
// ---------------------------------------------------------------------------
// fqps_dp
// record and scratch memories, head and count, sweep counters, output beat
// ---------------------------------------------------------------------------
module fqps_dp #(
    parameter int QUEUE_DEPTH = fqps_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  fqps_pkg::ctrl_cmd_t                  cmd,
    output fqps_pkg::dp_status_t                 sts,
    input  logic [2:0]                           s_cmd,
    input  logic [31:0]                          s_item_name_tag,
    input  logic signed [31:0]                   s_item_prize,
    input  logic [7:0]                           s_item_type,
    input  logic signed [31:0]                   s_item_time,
    input  logic [7:0]                           s_key_type,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [1:0]                           m_status,
    output logic [31:0]                          m_out_name_tag,
    output logic signed [31:0]                   m_out_prize,
    output logic [7:0]                           m_out_type,
    output logic signed [31:0]                   m_out_time,
    output logic signed [fqps_pkg::SUM_W-1:0]    m_prize_sum,
    output logic [fqps_pkg::OCC_W-1:0]           m_occupancy
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W = (AW+1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    // ring position of the record at a given offset from the head
    function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] head,
                                              input logic [AW-1:0] off);
        logic [AW:0] s;
        s = {1'b0, head} + {1'b0, off};
        if (s >= DEPTH_W) s = s - DEPTH_W;
        return s[AW-1:0];
    endfunction

    fqps_pkg::op_t     op_reg;
    fqps_pkg::rec_t    in_rec_reg;
    logic [7:0]        key_reg;
    logic [AW-1:0]     head_reg,       head_next;
    logic [CW-1:0]     count_reg,      count_next;
    logic [CW-1:0]     rd_off_reg,     rd_off_next;
    logic [CW-1:0]     proc_off_reg,   proc_off_next;
    logic              proc_valid_reg, proc_valid_next;
    logic [CW-1:0]     wr_n_reg,       wr_n_next;
    logic signed [fqps_pkg::SUM_W-1:0] sum_reg, sum_next;
    fqps_pkg::status_t res_status_reg, res_status_next;
    fqps_pkg::rec_t    res_rec_reg,    res_rec_next;

    logic              m_valid_reg;
    fqps_pkg::status_t m_status_reg;
    fqps_pkg::rec_t    m_rec_reg;
    logic signed [fqps_pkg::SUM_W-1:0] m_sum_reg;
    logic [fqps_pkg::OCC_W-1:0]        m_occ_reg;

    logic              empty, full, issue, is_copy, is_match, want_match;
    logic              main_wr_en, main_rd_en, scr_wr_en, scr_rd_en;
    logic [AW-1:0]     main_wr_addr, main_rd_addr;
    fqps_pkg::rec_t    main_wr_data, main_rd_data, scr_rd_data;
    logic [CW+fqps_pkg::OCC_W-1:0] occ_ext;

    assign empty      = (count_reg == '0);
    assign full       = (count_reg == DEPTH_C);
    assign is_copy    = (cmd.pass_sel == fqps_pkg::PASS_COPY);
    assign want_match = (cmd.pass_sel == fqps_pkg::PASS_MATCH);
    assign issue      = cmd.pass_run && (rd_off_reg != count_reg);
    assign is_match   = (main_rd_data.rtype == key_reg);

    // memory ports
    always_comb begin
        main_rd_en   = 1'b0;
        main_rd_addr = head_reg;
        main_wr_en   = 1'b0;
        main_wr_addr = slot_at(head_reg, count_reg[AW-1:0]);
        main_wr_data = in_rec_reg;
        if (cmd.exec) begin
            main_rd_en = !empty &&
                         ((op_reg == fqps_pkg::OP_DEQ) || (op_reg == fqps_pkg::OP_PEEK));
            main_wr_en = (op_reg == fqps_pkg::OP_ENQ) && !full;
        end
        if (issue && !is_copy) begin
            main_rd_en   = 1'b1;
            main_rd_addr = slot_at(head_reg, rd_off_reg[AW-1:0]);
        end
        if (cmd.pass_run && proc_valid_reg && is_copy) begin
            main_wr_en   = 1'b1;
            main_wr_addr = slot_at(head_reg, proc_off_reg[AW-1:0]);
            main_wr_data = scr_rd_data;
        end
    end

    assign scr_rd_en = issue && is_copy;
    assign scr_wr_en = cmd.pass_run && proc_valid_reg && !is_copy &&
                       (is_match == want_match);

    fqps_ram #(.WIDTH(fqps_pkg::REC_W), .DEPTH(QUEUE_DEPTH)) u_rec_ram (
        .aclk    (aclk),
        .wr_en   (main_wr_en),
        .wr_addr (main_wr_addr),
        .wr_data (main_wr_data),
        .rd_en   (main_rd_en),
        .rd_addr (main_rd_addr),
        .rd_data (main_rd_data)
    );

    fqps_ram #(.WIDTH(fqps_pkg::REC_W), .DEPTH(QUEUE_DEPTH)) u_scr_ram (
        .aclk    (aclk),
        .wr_en   (scr_wr_en),
        .wr_addr (wr_n_reg[AW-1:0]),
        .wr_data (main_rd_data),
        .rd_en   (scr_rd_en),
        .rd_addr (rd_off_reg[AW-1:0]),
        .rd_data (scr_rd_data)
    );

    // queue state, sweep counters and result
    always_comb begin
        head_next       = head_reg;
        count_next      = count_reg;
        rd_off_next     = rd_off_reg;
        proc_off_next   = proc_off_reg;
        proc_valid_next = 1'b0;
        wr_n_next       = wr_n_reg;
        sum_next        = sum_reg;
        res_status_next = res_status_reg;
        res_rec_next    = res_rec_reg;

        if (cmd.exec) begin
            res_status_next = fqps_pkg::STS_OK;
            res_rec_next    = '0;
            sum_next        = '0;
            rd_off_next     = '0;
            wr_n_next       = '0;
            unique case (op_reg) inside
                fqps_pkg::OP_ENQ: begin
                    if (full) res_status_next = fqps_pkg::STS_FULL;
                    else      count_next      = count_reg + 1'b1;
                end
                fqps_pkg::OP_DEQ: begin
                    if (empty) begin
                        res_status_next = fqps_pkg::STS_EMPTY;
                    end else begin
                        head_next  = slot_at(head_reg, AW'(1));
                        count_next = count_reg - 1'b1;
                    end
                end
                fqps_pkg::OP_CLEAR: begin
                    head_next  = '0;
                    count_next = '0;
                end
                fqps_pkg::OP_PEEK,
                fqps_pkg::OP_SUM: begin
                    if (empty) res_status_next = fqps_pkg::STS_EMPTY;
                end
                default: ;
            endcase
        end

        if (cmd.capture) res_rec_next = main_rd_data;

        if (cmd.pass_run) begin
            if (issue) begin
                rd_off_next     = rd_off_reg + 1'b1;
                proc_off_next   = rd_off_reg;
                proc_valid_next = 1'b1;
            end
            if (scr_wr_en) begin
                wr_n_next = wr_n_reg + 1'b1;
                if (want_match) begin
                    sum_next = sum_reg + fqps_pkg::SUM_W'(main_rd_data.prize);
                end
            end
            if (cmd.pass_restart) begin
                rd_off_next     = '0;
                proc_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg       <= '0;
            count_reg      <= '0;
            proc_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            head_reg       <= head_next;
            count_reg      <= count_next;
            proc_valid_reg <= proc_valid_next;
            if (cmd.emit)    m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    assign occ_ext = {{fqps_pkg::OCC_W{1'b0}}, count_reg};

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            op_reg            <= fqps_pkg::op_t'(s_cmd);
            in_rec_reg.tag    <= s_item_name_tag;
            in_rec_reg.prize  <= s_item_prize;
            in_rec_reg.rtype  <= s_item_type;
            in_rec_reg.tstamp <= s_item_time;
            key_reg           <= s_key_type;
        end
        rd_off_reg     <= rd_off_next;
        proc_off_reg   <= proc_off_next;
        wr_n_reg       <= wr_n_next;
        sum_reg        <= sum_next;
        res_status_reg <= res_status_next;
        res_rec_reg    <= res_rec_next;
        if (cmd.emit) begin
            m_status_reg <= res_status_reg;
            m_rec_reg    <= res_rec_reg;
            m_sum_reg    <= sum_reg;
            m_occ_reg    <= occ_ext[fqps_pkg::OCC_W-1:0];
        end
    end

    assign sts.op        = op_reg;
    assign sts.empty     = empty;
    assign sts.pass_done = (rd_off_reg == count_reg) && !proc_valid_reg;
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_out_name_tag = m_rec_reg.tag;
    assign m_out_prize    = m_rec_reg.prize;
    assign m_out_type     = m_rec_reg.rtype;
    assign m_out_time     = m_rec_reg.tstamp;
    assign m_prize_sum    = m_sum_reg;
    assign m_occupancy    = m_occ_reg;

endmodule

// ----- sv/fifo_with_type_partition_sum.sv -----
// enqueue, clear, unused codes and error cases: decode/execute, then the result emit;
//   dequeue and peek: decode/execute, a memory read wait, then the result emit
// prize sum with n records held: match and non-match sweeps over the n records in the record memory,
//   then a copy-back sweep from the scratch memory; each beat is done before the next is taken
// a finished result waits in the output register while the next beat is taken
// reset clears head, count, controller and output valid; memories are not cleared
// ---------------------------------------------------------------------------
// fifo_with_type_partition_sum
// bounded record queue with type-keyed prize sum and stable partition
// ---------------------------------------------------------------------------
module fifo_with_type_partition_sum #(
    parameter int QUEUE_DEPTH = fqps_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // command beat
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [2:0]                           s_cmd,
    input  logic [31:0]                          s_item_name_tag,
    input  logic signed [31:0]                   s_item_prize,
    input  logic [7:0]                           s_item_type,
    input  logic signed [31:0]                   s_item_time,
    input  logic [7:0]                           s_key_type,
    // result beat
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [1:0]                           m_status,
    output logic [31:0]                          m_out_name_tag,
    output logic signed [31:0]                   m_out_prize,
    output logic [7:0]                           m_out_type,
    output logic signed [31:0]                   m_out_time,
    output logic signed [fqps_pkg::SUM_W-1:0]    m_prize_sum,
    output logic [fqps_pkg::OCC_W-1:0]           m_occupancy
);

    // control and status between sequencer and datapath
    fqps_pkg::ctrl_cmd_t  ctrl_cmd;
    fqps_pkg::dp_status_t dp_sts;

    // sequencer: idle, decode/execute, read wait, match sweep,
    // non-match sweep, copy-back sweep, result emit
    fqps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (dp_sts),
        .cmd     (ctrl_cmd)
    );

    // datapath: ring of records, scratch for the partitioned order,
    // prize accumulator and the output register
    fqps_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (ctrl_cmd),
        .sts             (dp_sts),
        .s_cmd           (s_cmd),
        .s_item_name_tag (s_item_name_tag),
        .s_item_prize    (s_item_prize),
        .s_item_type     (s_item_type),
        .s_item_time     (s_item_time),
        .s_key_type      (s_key_type),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_out_name_tag  (m_out_name_tag),
        .m_out_prize     (m_out_prize),
        .m_out_type      (m_out_type),
        .m_out_time      (m_out_time),
        .m_prize_sum     (m_prize_sum),
        .m_occupancy     (m_occupancy)
    );

endmodule

// ----- sv/fqps_checker.sv -----
// ---------------------------------------------------------------------------
// fqps_checker
// port-level checks on the record queue, bound to the top level
// ---------------------------------------------------------------------------
module fqps_checker #(
    parameter int QUEUE_DEPTH = fqps_pkg::QUEUE_DEPTH_DEF
) (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [1:0]                        m_status,
    input logic [31:0]                       m_out_name_tag,
    input logic [fqps_pkg::SUM_W-1:0]        m_prize_sum,
    input logic [fqps_pkg::OCC_W-1:0]        m_occupancy
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_occupancy))
        else $error("stalled result beat changed");

    // one command at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("command beat taken while busy");

    // dropped enqueue only when the queue is at capacity
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == fqps_pkg::STS_FULL) |->
            (m_occupancy == fqps_pkg::OCC_W'(QUEUE_DEPTH)))
        else $error("full status with queue not at capacity");

    // empty status carries no record and no sum
    a_empty_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == fqps_pkg::STS_EMPTY) |->
            (m_occupancy == '0) && (m_prize_sum == '0) && (m_out_name_tag == '0))
        else $error("empty status with data or records held");

    // occupancy never beyond capacity, checked for depths up to 31
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (QUEUE_DEPTH > 31) || (int'(m_occupancy) <= QUEUE_DEPTH))
        else $error("occupancy beyond capacity");

endmodule

bind fifo_with_type_partition_sum fqps_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_fqps_checker (.*);
